[rtl/core/ssds_pkg.sv]
package ssds_pkg;

    // field widths
    localparam int unsigned ValueWidth = 11;
    localparam int unsigned PosWidth   = 2;
    localparam int unsigned SegWidth   = 8;
    localparam int unsigned DigitWidth = 4;
    localparam int unsigned RemWidth   = 7;

    // result queue depth default
    localparam int unsigned QueueDepthDefault = 4;

    // item kinds
    typedef enum logic {
        FUNC_LOAD = 1'b0,
        FUNC_TICK = 1'b1
    } func_t;

    // display positions
    localparam logic [PosWidth-1:0] POS_SIGN     = 2'd0;
    localparam logic [PosWidth-1:0] POS_HUNDREDS = 2'd1;
    localparam logic [PosWidth-1:0] POS_TENS     = 2'd2;
    localparam logic [PosWidth-1:0] POS_ONES     = 2'd3;

    // special segment patterns
    localparam logic [SegWidth-1:0] SEG_MINUS = 8'h40;
    localparam logic [SegWidth-1:0] SEG_DP    = 8'h80;
    localparam logic [SegWidth-1:0] SEG_BLANK = 8'h00;

    // registered input word: kind, sign, hundreds digit and remainder below one hundred
    typedef struct packed {
        func_t                 func;
        logic                  neg;
        logic [DigitWidth-1:0] hundreds;
        logic [RemWidth-1:0]   rem;
    } split_word_t;

    // one queue entry; a tick carries a blanking result ahead of the new position
    typedef struct packed {
        logic                tick;
        logic [PosWidth-1:0] first_pos;
        logic [PosWidth-1:0] pos;
        logic [SegWidth-1:0] seg;
    } scan_word_t;

    // digit to segment pattern, blank for codes above nine
    function automatic logic [SegWidth-1:0] digit_pattern(input logic [DigitWidth-1:0] d);
        logic [SegWidth-1:0] p;
        case (d)
            4'd0:    p = 8'h3f;
            4'd1:    p = 8'h06;
            4'd2:    p = 8'h5b;
            4'd3:    p = 8'h4f;
            4'd4:    p = 8'h66;
            4'd5:    p = 8'h6d;
            4'd6:    p = 8'h7d;
            4'd7:    p = 8'h07;
            4'd8:    p = 8'h7f;
            4'd9:    p = 8'h6f;
            default: p = SEG_BLANK;
        endcase
        return p;
    endfunction

    // pattern shown at a given position
    function automatic logic [SegWidth-1:0] position_pattern(
        input logic [PosWidth-1:0]   pos,
        input logic [DigitWidth-1:0] hundreds,
        input logic [DigitWidth-1:0] tens,
        input logic [DigitWidth-1:0] ones
    );
        logic [SegWidth-1:0] p;
        case (pos)
            POS_SIGN:     p = SEG_MINUS;
            POS_HUNDREDS: p = digit_pattern(hundreds);
            POS_TENS:     p = digit_pattern(tens) | SEG_DP;
            default:      p = digit_pattern(ones);
        endcase
        return p;
    endfunction

    // tens digit of a value below one hundred, x*205 >> 11
    function automatic logic [DigitWidth-1:0] tens_of(input logic [RemWidth-1:0] rem);
        logic [RemWidth+7:0] prod;
        prod = {8'd0, rem} * 15'd205;
        return prod[RemWidth+7:11];
    endfunction

    // ones digit of a value below one hundred
    function automatic logic [DigitWidth-1:0] ones_of(input logic [RemWidth-1:0] rem);
        logic [RemWidth-1:0] tens_part;
        logic [RemWidth-1:0] diff;
        tens_part = RemWidth'(tens_of(rem) * 4'd10);
        diff      = rem - tens_part;
        return diff[DigitWidth-1:0];
    endfunction

endpackage

[rtl/core/ssds_split.sv]
module ssds_split (
    input  logic                                  func,
    input  logic signed [ssds_pkg::ValueWidth-1:0] value,
    output ssds_pkg::split_word_t                 word
);
    import ssds_pkg::*;

    logic [ValueWidth-1:0] raw;
    logic [ValueWidth-1:0] mag;
    logic [ValueWidth+5:0] prod;
    logic [4:0]            q100;
    logic [4:0]            q_wrap;
    logic [ValueWidth-1:0] hund_part;
    logic [ValueWidth-1:0] rem_full;

    // magnitude, then split by one hundred with a reciprocal multiply (m*41 >> 12)
    always_comb
    begin
        raw       = ValueWidth'(value);
        mag       = raw[ValueWidth-1] ? (~raw + 1'b1) : raw;
        prod      = {6'd0, mag} * 17'd41;
        q100      = prod[ValueWidth+5:12];
        hund_part = ValueWidth'(q100 * 7'd100);
        rem_full  = mag - hund_part;
        // thousands digit dropped
        q_wrap    = (q100 >= 5'd10) ? (q100 - 5'd10) : q100;

        word.func     = func_t'(func);
        word.neg      = raw[ValueWidth-1];
        word.hundreds = q_wrap[DigitWidth-1:0];
        word.rem      = rem_full[RemWidth-1:0];
    end

endmodule

[rtl/core/ssds_scan.sv]
module ssds_scan (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  step,
    input  ssds_pkg::split_word_t word,
    output ssds_pkg::scan_word_t  entry
);
    import ssds_pkg::*;

    logic                  neg_reg;
    logic                  neg_next;
    logic [DigitWidth-1:0] hundreds_reg;
    logic [DigitWidth-1:0] hundreds_next;
    logic [DigitWidth-1:0] tens_reg;
    logic [DigitWidth-1:0] tens_next;
    logic [DigitWidth-1:0] ones_reg;
    logic [DigitWidth-1:0] ones_next;
    logic [PosWidth-1:0]   pos_reg;
    logic [PosWidth-1:0]   pos_next;
    logic [PosWidth-1:0]   adv;

    // load restarts the scan, tick blanks and advances
    always_comb
    begin
        neg_next      = neg_reg;
        hundreds_next = hundreds_reg;
        tens_next     = tens_reg;
        ones_next     = ones_reg;
        adv           = pos_reg + 1'b1;
        if (adv == POS_SIGN && !neg_reg)
        begin
            adv = POS_HUNDREDS;
        end
        if (word.func == FUNC_LOAD)
        begin
            neg_next        = word.neg;
            hundreds_next   = word.hundreds;
            tens_next       = tens_of(word.rem);
            ones_next       = ones_of(word.rem);
            pos_next        = word.neg ? POS_SIGN : POS_HUNDREDS;
            entry.tick      = 1'b0;
            entry.first_pos = pos_next;
        end
        else
        begin
            pos_next        = adv;
            entry.tick      = 1'b1;
            entry.first_pos = pos_reg;
        end
        entry.pos = pos_next;
        entry.seg = position_pattern(pos_next, hundreds_next, tens_next, ones_next);
    end

    // display state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            neg_reg      <= 1'b0;
            hundreds_reg <= '0;
            tens_reg     <= '0;
            ones_reg     <= '0;
            pos_reg      <= POS_HUNDREDS;
        end
        else if (step)
        begin
            neg_reg      <= neg_next;
            hundreds_reg <= hundreds_next;
            tens_reg     <= tens_next;
            ones_reg     <= ones_next;
            pos_reg      <= pos_next;
        end
    end

endmodule

[rtl/core/ssds_fifo.sv]
module ssds_fifo #(
    parameter int unsigned Depth = ssds_pkg::QueueDepthDefault
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  ssds_pkg::scan_word_t wdata,
    input  logic                 pop,
    output logic                 full,
    output logic                 empty,
    output ssds_pkg::scan_word_t head
);
    import ssds_pkg::*;

    localparam int unsigned PtrWidth   = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int unsigned CountWidth = $clog2(Depth + 1);
    localparam logic [PtrWidth-1:0]   LastPtr  = PtrWidth'(Depth - 1);
    localparam logic [CountWidth-1:0] FullCnt  = CountWidth'(Depth);

    scan_word_t             entry_reg [Depth];
    logic [PtrWidth-1:0]    wr_ptr_reg;
    logic [PtrWidth-1:0]    wr_ptr_next;
    logic [PtrWidth-1:0]    rd_ptr_reg;
    logic [PtrWidth-1:0]    rd_ptr_next;
    logic [CountWidth-1:0]  count_reg;
    logic [CountWidth-1:0]  count_next;

    assign full  = (count_reg == FullCnt);
    assign empty = (count_reg == '0);
    assign head  = entry_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LastPtr) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LastPtr) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

[rtl/core/signed_seven_segment_scanner_core.sv]
// An accepted word waits in the input register and enters the result queue when
// the queue has room; its first result word is valid once it is in the queue.
// Throughput: one input word per cycle while the queue is not full; a load gives
// one result word and a tick two, and the single result port delivering one word a
// cycle while result_stall is low sets the tick rate. Reset: queue and input register
// empty, display state a non-negative zero with the scan at the hundreds position.
module signed_seven_segment_scanner_core #(
    parameter int unsigned QUEUE_DEPTH = ssds_pkg::QueueDepthDefault
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   item_valid,
    output logic                                   item_stall,
    input  logic                                   func,
    input  logic signed [ssds_pkg::ValueWidth-1:0] value,
    output logic                                   result_valid,
    input  logic                                   result_stall,
    output logic [ssds_pkg::PosWidth-1:0]          digit_select,
    output logic [ssds_pkg::SegWidth-1:0]          segments,
    output logic                                   last_of_run
);
    import ssds_pkg::*;

    split_word_t split_comb;
    split_word_t split_reg;
    logic        hold_valid_reg;
    logic        hold_valid_next;
    logic        accept;
    logic        step;
    scan_word_t  entry;
    scan_word_t  head;
    logic        q_full;
    logic        q_empty;
    logic        second;
    logic        pop;
    logic        phase_reg;
    logic        phase_next;

    // sign and hundreds split ahead of the input register
    ssds_split u_split (
        .func  (func),
        .value (value),
        .word  (split_comb)
    );

    // input register handshake
    assign item_stall = hold_valid_reg && q_full;
    assign accept     = item_valid && !item_stall;
    assign step       = hold_valid_reg && !q_full;

    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        if (accept)
        begin
            hold_valid_next = 1'b1;
        end
        else if (step)
        begin
            hold_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            split_reg <= split_comb;
        end
    end

    // scan state and pattern generation
    ssds_scan u_scan (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .word  (split_reg),
        .entry (entry)
    );

    // result queue
    ssds_fifo #(
        .Depth (QUEUE_DEPTH)
    ) u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (step),
        .wdata (entry),
        .pop   (pop),
        .full  (q_full),
        .empty (q_empty),
        .head  (head)
    );

    // output side: a tick entry gives its blanking word first
    assign result_valid = !q_empty;
    assign second       = !head.tick || phase_reg;
    assign digit_select = second ? head.pos : head.first_pos;
    assign segments     = second ? head.seg : SEG_BLANK;
    assign last_of_run  = second;
    assign pop          = result_valid && !result_stall && second;

    always_comb
    begin
        phase_next = phase_reg;
        if (result_valid && !result_stall)
        begin
            phase_next = !second;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            phase_reg      <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
            phase_reg      <= phase_next;
        end
    end

endmodule

[rtl/core/ssds_checker.sv]
module ssds_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          result_valid,
    input logic                          result_stall,
    input logic [ssds_pkg::PosWidth-1:0] digit_select,
    input logic [ssds_pkg::SegWidth-1:0] segments,
    input logic                          last_of_run
);
    import ssds_pkg::*;

    // a blanking word is always followed by the new position's word
    a_blank_then_more: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_stall && !last_of_run |=> result_valid)
        else $error("blanking word not followed by a result");

    // a blanking word carries no lit segment
    a_blank_dark: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !last_of_run |-> segments == SEG_BLANK)
        else $error("blanking word has lit segments");

    // a word at the sign position that is not a blanking word shows a minus
    a_sign_minus: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && last_of_run && digit_select == POS_SIGN |-> segments == SEG_MINUS)
        else $error("sign position shows something other than a minus");

    // a word at the tens position that is not a blanking word lights the decimal point
    a_tens_dp: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && last_of_run && digit_select == POS_TENS |-> segments[SegWidth-1])
        else $error("tens position without decimal point");

    // a stalled result word holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(digit_select)
            && $stable(segments) && $stable(last_of_run))
        else $error("stalled result word changed");

endmodule

bind signed_seven_segment_scanner_core ssds_checker u_ssds_checker (.*);

[tb/sv/signed_seven_segment_scanner_core_tb.sv]
module signed_seven_segment_scanner_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ssds_pkg::*;

    // one display word as it leaves the block
    typedef struct packed {
        logic [PosWidth-1:0] pos;
        logic [SegWidth-1:0] seg;
        logic                last;
    } scan_out_t;

    // one row of the directed table; the pattern is typed in when known
    typedef struct packed {
        func_t                 kind;
        logic [ValueWidth-1:0] val;
        logic                  typed;
        logic [PosWidth-1:0]   pos;
        logic [SegWidth-1:0]   seg;
    } stim_row_t;

    localparam int NumDirected = 25;
    localparam int NumRandom   = 1625;
    localparam int QuietTail   = 150;

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         item_valid = 1'b0;
    logic                         item_stall;
    func_t                        item_func = FUNC_LOAD;
    logic signed [ValueWidth-1:0] item_value = '0;
    logic                         result_valid;
    logic                         result_stall = 1'b0;
    logic [PosWidth-1:0]          digit_select;
    logic [SegWidth-1:0]          segments;
    logic                         last_of_run;

    // display state as the block should hold it
    logic                  shown_neg;
    logic [DigitWidth-1:0] shown_hundreds;
    logic [DigitWidth-1:0] shown_tens;
    logic [DigitWidth-1:0] shown_ones;
    logic [PosWidth-1:0]   scan_pos;

    scan_out_t pending_words[$];
    stim_row_t directed_rows[NumDirected];
    int        errors = 0;
    int        idle_odds = 0;
    int        stall_left = 0;

    // output words sampled mid-cycle, away from the driving edge
    logic      snap_rst;
    logic      snap_valid;
    logic      snap_stall;
    scan_out_t snap_word;

    signed_seven_segment_scanner_core DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .func         (item_func),
        .value        (item_value),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .digit_select (digit_select),
        .segments     (segments),
        .last_of_run  (last_of_run)
    );

    always #10 clk = ~clk;

    // seven-segment glyph of a decimal digit, dark above nine
    function automatic logic [SegWidth-1:0] glyph(input logic [DigitWidth-1:0] d);
        logic [SegWidth-1:0] g;
        case (d)
            4'd0:    g = 8'h3f;
            4'd1:    g = 8'h06;
            4'd2:    g = 8'h5b;
            4'd3:    g = 8'h4f;
            4'd4:    g = 8'h66;
            4'd5:    g = 8'h6d;
            4'd6:    g = 8'h7d;
            4'd7:    g = 8'h07;
            4'd8:    g = 8'h7f;
            4'd9:    g = 8'h6f;
            default: g = SEG_BLANK;
        endcase
        return g;
    endfunction

    // pattern lit at a position for the current display state
    function automatic logic [SegWidth-1:0] lit_pattern(input logic [PosWidth-1:0] p);
        logic [SegWidth-1:0] g;
        case (p)
            POS_SIGN:     g = SEG_MINUS;
            POS_HUNDREDS: g = glyph(shown_hundreds);
            POS_TENS:     g = glyph(shown_tens) | SEG_DP;
            default:      g = glyph(shown_ones);
        endcase
        return g;
    endfunction

    // advance the display state by one word and queue the words it gives
    function automatic void predict_display(input func_t f,
                                            input logic signed [ValueWidth-1:0] v);
        int mag;
        if (f == FUNC_LOAD) begin
            shown_neg      = v[ValueWidth-1];
            mag            = shown_neg ? -int'(v) : int'(v);
            shown_hundreds = DigitWidth'((mag / 100) % 10);
            shown_tens     = DigitWidth'((mag / 10) % 10);
            shown_ones     = DigitWidth'(mag % 10);
            scan_pos       = shown_neg ? POS_SIGN : POS_HUNDREDS;
            pending_words.push_back('{scan_pos, lit_pattern(scan_pos), 1'b1});
        end
        else begin
            pending_words.push_back('{scan_pos, SEG_BLANK, 1'b0});
            scan_pos = scan_pos + 1'b1;
            if (scan_pos == POS_SIGN && !shown_neg)
                scan_pos = POS_HUNDREDS;
            pending_words.push_back('{scan_pos, lit_pattern(scan_pos), 1'b1});
        end
    endfunction

    // offer one input word and wait until it is taken
    task automatic send_word(input func_t f, input logic signed [ValueWidth-1:0] v);
        bit took;
        took = 1'b0;
        if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        item_valid <= 1'b1;
        item_func  <= f;
        item_value <= v;
        while (!took) begin
            @(negedge clk);
            took = !item_stall;
            @(posedge clk);
        end
        predict_display(f, v);
    endtask

    // receiver stalls in random bursts
    always @(posedge clk) begin
        if (stall_left > 0) begin
            stall_left   <= stall_left - 1;
            result_stall <= (stall_left > 1);
        end
        else if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
            stall_left   <= $urandom_range(1, 5);
            result_stall <= 1'b1;
        end
        else begin
            result_stall <= 1'b0;
        end
    end

    always @(negedge clk) begin
        snap_rst   = rst_n;
        snap_valid = result_valid;
        snap_stall = result_stall;
        snap_word  = '{digit_select, segments, last_of_run};
    end

    // compare each word taken from the block with the oldest expected one
    always @(posedge clk) begin
        scan_out_t want;
        if (snap_rst && snap_valid && !snap_stall) begin
            if (pending_words.size() == 0) begin
                errors = errors + 1;
                if (errors <= 10)
                    $display("unexpected word: pos %0d seg %02h last %0d",
                             snap_word.pos, snap_word.seg, snap_word.last);
            end
            else begin
                want = pending_words.pop_front();
                if (want != snap_word) begin
                    errors = errors + 1;
                    if (errors <= 10)
                        $display({"mismatch: expected pos %0d seg %02h last %0d,",
                                  " got pos %0d seg %02h last %0d"},
                                 want.pos, want.seg, want.last,
                                 snap_word.pos, snap_word.seg, snap_word.last);
                end
            end
        end
    end

    // main sequence
    initial begin
        func_t                        f;
        logic signed [ValueWidth-1:0] v;

        shown_neg      = 1'b0;
        shown_hundreds = '0;
        shown_tens     = '0;
        shown_ones     = '0;
        scan_pos       = POS_HUNDREDS;

        // ticks from reset, extremes, out-of-range magnitudes, sign wrap
        directed_rows = '{
            '{FUNC_TICK, 11'sd0,     1'b1, POS_TENS,     8'hbf},
            '{FUNC_TICK, 11'sd0,     1'b1, POS_ONES,     8'h3f},
            '{FUNC_TICK, 11'sd0,     1'b1, POS_HUNDREDS, 8'h3f},
            '{FUNC_LOAD, 11'sd0,     1'b1, POS_HUNDREDS, 8'h3f},
            '{FUNC_LOAD, 11'sd999,   1'b1, POS_HUNDREDS, 8'h6f},
            '{FUNC_TICK, 11'sd0,     1'b0, POS_SIGN,     SEG_BLANK},
            '{FUNC_TICK, 11'sd0,     1'b0, POS_SIGN,     SEG_BLANK},
            '{FUNC_TICK, 11'sd0,     1'b0, POS_SIGN,     SEG_BLANK},
            '{FUNC_LOAD, -11'sd999,  1'b1, POS_SIGN,     SEG_MINUS},
            '{FUNC_TICK, 11'sd0,     1'b0, POS_SIGN,     SEG_BLANK},
            '{FUNC_TICK, 11'sd0,     1'b0, POS_SIGN,     SEG_BLANK},
            '{FUNC_TICK, 11'sd0,     1'b0, POS_SIGN,     SEG_BLANK},
            '{FUNC_TICK, 11'sd0,     1'b0, POS_SIGN,     SEG_BLANK},
            '{FUNC_LOAD, -11'sd1,    1'b1, POS_SIGN,     SEG_MINUS},
            '{FUNC_TICK, 11'sd0,     1'b0, POS_SIGN,     SEG_BLANK},
            '{FUNC_LOAD, 11'sd1023,  1'b1, POS_HUNDREDS, 8'h3f},
            '{FUNC_TICK, 11'sd0,     1'b0, POS_SIGN,     SEG_BLANK},
            '{FUNC_TICK, 11'sd0,     1'b0, POS_SIGN,     SEG_BLANK},
            '{FUNC_LOAD, -11'sd1024, 1'b1, POS_SIGN,     SEG_MINUS},
            '{FUNC_TICK, 11'sd0,     1'b0, POS_SIGN,     SEG_BLANK},
            '{FUNC_TICK, 11'sd0,     1'b0, POS_SIGN,     SEG_BLANK},
            '{FUNC_TICK, 11'sd0,     1'b0, POS_SIGN,     SEG_BLANK},
            '{FUNC_TICK, 11'sd0,     1'b0, POS_SIGN,     SEG_BLANK},
            '{FUNC_LOAD, 11'sd1000,  1'b1, POS_HUNDREDS, 8'h3f},
            '{FUNC_LOAD, -11'sd1000, 1'b1, POS_SIGN,     SEG_MINUS}
        };

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table, no idling
        for (int i = 0; i < NumDirected; i++) begin
            send_word(directed_rows[i].kind, directed_rows[i].val);
            if (directed_rows[i].typed) begin
                pending_words[pending_words.size() - 1].pos = directed_rows[i].pos;
                pending_words[pending_words.size() - 1].seg = directed_rows[i].seg;
            end
        end

        // random words: mostly ticks, loads mostly within -999 to 999 and over the full 11-bit range now and then
        for (int i = 0; i < NumRandom; i++) begin
            if (i % 100 == 0)
                idle_odds = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(2, 8);
            if (i >= NumRandom - QuietTail)
                idle_odds = 0;
            if ($urandom_range(0, 4) == 0) begin
                f = FUNC_LOAD;
                if ($urandom_range(0, 6) == 0)
                    v = ValueWidth'($urandom_range(0, 2047));
                else
                    v = ValueWidth'(int'($urandom_range(0, 1998)) - 999);
            end
            else begin
                f = FUNC_TICK;
                v = ValueWidth'($urandom_range(0, 2047));
            end
            send_word(f, v);
        end
        item_valid <= 1'b0;

        // drain, then watch for stray words
        while (pending_words.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // watchdog
    initial begin
        #20_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
